// File: rtl/core/ttop_pkg.sv
// ----------------------------------------------------------------------------
// ttop_pkg
// shared types, constants and helpers of the track table predictor
// ----------------------------------------------------------------------------
package ttop_pkg;

  localparam int SLOTS   = 128;
  localparam int SLOT_W  = 7;
  localparam int HIST_D  = 45;
  localparam int HIST_N  = SLOTS * HIST_D;
  localparam int HIST_AW = $clog2(HIST_N);
  localparam int HCNT_W  = 6;
  localparam int STEPS   = 15;
  localparam int K_W     = $clog2(STEPS + 1);
  localparam int T_W     = 10;
  localparam int DVD_W   = 64;
  localparam int DVS_W   = 21;
  localparam int NUM_W   = 50;
  localparam int SY_W    = 38;
  localparam int STY_W   = 42;
  localparam int ST_W    = 10;
  localparam int STT_W   = 16;

  localparam logic [1:0] KIND_POINT   = 2'd0;
  localparam logic [1:0] KIND_REMOVED = 2'd1;
  localparam logic [1:0] KIND_IGNORED = 2'd2;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_STRIDE    = 1'b1;

  typedef struct packed {
    logic [15:0]        target_id;
    logic signed [31:0] report_lat;
    logic signed [31:0] report_lon;
    logic               alive;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [6:0]         slot;
    logic               new_track;
    logic [3:0]         step;
    logic signed [31:0] pred_lat;
    logic signed [31:0] pred_lon;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [15:0]       id;
    logic [31:0]       cur_lat;
    logic [31:0]       cur_lon;
    logic [HCNT_W-1:0] head;
    logic [HCNT_W-1:0] cnt;
  } rec_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRCH, ST_DECIDE, ST_REMOVE, ST_IGNORE, ST_CREATE, ST_UPDATE,
    ST_SUMS, ST_MUL1, ST_MUL2, ST_DIV_GO, ST_DIV_WAIT, ST_BMUL, ST_PREP, ST_EMIT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       srch;
    logic       remove;
    logic       ignore;
    logic       create;
    logic       update;
    logic       sums;
    logic       mul1;
    logic       mul2;
    logic       div_go;
    logic [1:0] div_sel;
    logic       bmul;
    logic       prep;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic srch_done;
    logic match;
    logic free;
    logic alive;
    logic few;
    logic sums_done;
    logic div_done;
    logic emit_last;
  } stat_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [HIST_AW-1:0] hist_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [HCNT_W-1:0] i);
    return HIST_AW'(s) * HIST_AW'(HIST_D) + HIST_AW'(i);
  endfunction

endpackage

// File: rtl/core/ttop_ram.sv
// ----------------------------------------------------------------------------
// ttop_ram
// generic simple dual port ram, one write port, registered read port
// ----------------------------------------------------------------------------
module ttop_ram #(
  parameter int W = 32,
  parameter int D = 128
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ttop_div.sv
// ----------------------------------------------------------------------------
// ttop_div
// radix-2 signed by positive divider, quotient truncated toward zero
// ----------------------------------------------------------------------------
module ttop_div import ttop_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DVD_W-1:0] dvd,
  input  logic [DVS_W-1:0] dvs,
  output logic             done,
  output logic [DVD_W-1:0] quo
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W:0]   sh;
  logic [DVS_W:0]   diff;

  assign sh   = {rem_r, quo_r[DVD_W-1]};
  assign diff = sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      neg_r <= dvd[DVD_W-1];
      quo_r <= dvd[DVD_W-1] ? (DVD_W'(0) - dvd) : dvd;
      rem_r <= '0;
      dvs_r <= dvs;
    end else if (run_r) begin
      // restoring step, one quotient bit
      if (!diff[DVS_W]) begin
        rem_r <= diff[DVS_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= sh[DVS_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? (DVD_W'(0) - quo_r) : quo_r;

endmodule

// File: rtl/core/ttop_ctrl.sv
// ----------------------------------------------------------------------------
// ttop_ctrl
// sequencer of search, update, fit, divisions and emission
// ----------------------------------------------------------------------------
module ttop_ctrl import ttop_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    cmd         = '0;
    cmd.div_sel = sel_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        cmd.srch = 1'b1;
        if (stat.srch_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (stat.match && !stat.alive) state_nxt = ST_REMOVE;
        else if (stat.match)                    state_nxt = ST_UPDATE;
        else if (stat.alive && stat.free)       state_nxt = ST_CREATE;
        else                                    state_nxt = ST_IGNORE;
      end
      ST_REMOVE: begin
        cmd.remove = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_IGNORE: begin
        cmd.ignore = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_CREATE: begin
        cmd.create = 1'b1;
        state_nxt  = ST_PREP;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = stat.few ? ST_PREP : ST_SUMS;
      end
      ST_SUMS: begin
        cmd.sums = 1'b1;
        if (stat.sums_done) state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        sel_nxt   = 2'd0;
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          sel_nxt = sel_r + 2'd1;
          unique case (sel_r)
            2'd1:    state_nxt = ST_BMUL;
            2'd3:    state_nxt = ST_PREP;
            default: state_nxt = ST_DIV_GO;
          endcase
        end
      end
      ST_BMUL: begin
        cmd.bmul  = 1'b1;
        state_nxt = ST_DIV_GO;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: rtl/core/ttop_dp.sv
// ----------------------------------------------------------------------------
// ttop_dp
// track table datapath: slot records, history store, sums, fit, points
// ----------------------------------------------------------------------------
module ttop_dp import ttop_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  in_t         in_item,
  input  logic [15:0] thr,
  input  logic [3:0]  stride,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic        out_valid,
  output out_t        out_item
);

  // control state
  logic [SLOTS-1:0]  active_r;
  logic              out_valid_r;

  // payload state
  in_t               in_r;
  out_t              out_r;
  out_t              out_nxt;
  rec_t              rec_r;
  logic [SLOT_W-1:0] srch_idx_r, cmp_idx_r, free_slot_r, slot_r;
  logic              cmp_v_r, free_r, match_r, nt_r;
  logic [31:0]       vlat_r, vlon_r;
  logic [HCNT_W-1:0] n_r, hidx_r, rd_i_r, acc_t_r;
  logic              acc_v_r;
  logic [ST_W-1:0]   st_r;
  logic [STT_W-1:0]  stt_r;
  logic signed [SY_W-1:0]  sy_lat_r, sy_lon_r;
  logic signed [STY_W-1:0] sty_lat_r, sty_lon_r;
  logic signed [NUM_W-2:0] p_nsty_lat_r, p_stsy_lat_r, p_nsty_lon_r, p_stsy_lon_r;
  logic [DVS_W:0]    p_nstt_r;
  logic [2*ST_W-1:0] p_stst_r;
  logic signed [NUM_W-1:0] num_lat_r, num_lon_r;
  logic [DVS_W-1:0]  d_r;
  logic signed [NUM_W-1:0] a_lat_r, a_lon_r;
  logic signed [NUM_W+ST_W:0] am_lat_r, am_lon_r;
  logic [31:0]       b_lat_r, b_lon_r;
  logic [31:0]       slope_lat_r, slope_lon_r, base_lat_r, base_lon_r;
  logic [T_W-1:0]    t_r;
  logic [K_W-1:0]    k_r;

  // memories
  rec_t              rec_rd, rec_wr;
  logic              rec_we;
  logic [63:0]       hist_rd;
  logic              hist_we;
  logic [HIST_AW-1:0] hist_waddr, hist_raddr;

  ttop_ram #(.W($bits(rec_t)), .D(SLOTS)) u_rec (
    .clk   (clk),
    .we    (rec_we),
    .waddr (slot_r),
    .wdata (rec_wr),
    .raddr (srch_idx_r),
    .rdata (rec_rd)
  );

  ttop_ram #(.W(64), .D(HIST_N)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata ({rec_r.cur_lat, rec_r.cur_lon}),
    .raddr (hist_raddr),
    .rdata (hist_rd)
  );

  // divider
  logic [DVD_W-1:0] div_dvd, div_quo;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic signed [NUM_W+ST_W+1:0] bdv_lat, bdv_lon;

  ttop_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.div_go),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .done  (div_done),
    .quo   (div_quo)
  );

  // search compare
  logic hit, srch_end;
  assign hit      = cmp_v_r && active_r[cmp_idx_r] && (rec_rd.id == in_r.target_id);
  assign srch_end = cmp_v_r && (cmp_idx_r == SLOT_W'(SLOTS - 1));

  // track update
  logic [31:0]       upd_vlat, upd_vlon;
  logic              push;
  logic [HCNT_W-1:0] head_nxt, cnt_nxt;
  logic [HCNT_W:0]   hstart;

  always_comb begin
    upd_vlat = in_r.report_lat - rec_r.cur_lat;
    upd_vlon = in_r.report_lon - rec_r.cur_lon;
    push     = (mag32(upd_vlat) > {16'd0, thr}) || (mag32(upd_vlon) > {16'd0, thr});
    head_nxt = rec_r.head;
    cnt_nxt  = rec_r.cnt;
    if (push) begin
      head_nxt = (rec_r.head == HCNT_W'(HIST_D - 1)) ? '0 : rec_r.head + HCNT_W'(1);
      if (rec_r.cnt < HCNT_W'(HIST_D)) cnt_nxt = rec_r.cnt + HCNT_W'(1);
    end
    hstart = {1'b0, head_nxt} + (HCNT_W + 1)'(HIST_D) - {1'b0, cnt_nxt};
    if (hstart >= (HCNT_W + 1)'(HIST_D)) hstart = hstart - (HCNT_W + 1)'(HIST_D);
  end

  always_comb begin
    rec_we        = cmd.create || cmd.update;
    rec_wr.id     = in_r.target_id;
    rec_wr.cur_lat = in_r.report_lat;
    rec_wr.cur_lon = in_r.report_lon;
    rec_wr.head   = cmd.update ? head_nxt : '0;
    rec_wr.cnt    = cmd.update ? cnt_nxt : '0;
    hist_we       = cmd.update && push;
    hist_waddr    = hist_addr(slot_r, rec_r.head);
    hist_raddr    = hist_addr(slot_r, hidx_r);
  end

  // history sums
  logic signed [SY_W-1:0]  hla, hlo;
  logic signed [38:0]      tla, tlo;
  assign hla = SY_W'($signed(hist_rd[63:32]));
  assign hlo = SY_W'($signed(hist_rd[31:0]));
  assign tla = $signed({1'b0, acc_t_r}) * $signed(hist_rd[63:32]);
  assign tlo = $signed({1'b0, acc_t_r}) * $signed(hist_rd[31:0]);

  // b dividends
  assign bdv_lat = (NUM_W + ST_W + 2)'(sy_lat_r) - (NUM_W + ST_W + 2)'(am_lat_r);
  assign bdv_lon = (NUM_W + ST_W + 2)'(sy_lon_r) - (NUM_W + ST_W + 2)'(am_lon_r);

  always_comb begin
    unique case (cmd.div_sel)
      2'd0: begin
        div_dvd = DVD_W'(num_lat_r);
        div_dvs = d_r;
      end
      2'd1: begin
        div_dvd = DVD_W'(num_lon_r);
        div_dvs = d_r;
      end
      2'd2: begin
        div_dvd = DVD_W'(bdv_lat);
        div_dvs = DVS_W'(n_r);
      end
      default: begin
        div_dvd = DVD_W'(bdv_lon);
        div_dvs = DVS_W'(n_r);
      end
    endcase
  end

  // predicted point
  logic [31:0] pred_lat, pred_lon;
  assign pred_lat = base_lat_r + 32'(slope_lat_r * 32'(t_r));
  assign pred_lon = base_lon_r + 32'(slope_lon_r * 32'(t_r));

  // next result item
  always_comb begin
    out_nxt = '0;
    priority if (cmd.remove) begin
      out_nxt.kind = KIND_REMOVED;
      out_nxt.slot = slot_r;
      out_nxt.last = 1'b1;
    end else if (cmd.ignore) begin
      out_nxt.kind = KIND_IGNORED;
      out_nxt.last = 1'b1;
    end else if (cmd.emit) begin
      out_nxt.kind      = KIND_POINT;
      out_nxt.slot      = slot_r;
      out_nxt.new_track = nt_r;
      out_nxt.step      = 4'(k_r);
      out_nxt.pred_lat  = pred_lat;
      out_nxt.pred_lon  = pred_lon;
      out_nxt.last      = (k_r == K_W'(STEPS));
    end else begin
      out_nxt.kind = KIND_POINT;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.remove || cmd.ignore || cmd.emit;
      if (cmd.remove) active_r[slot_r] <= 1'b0;
      if (cmd.create) active_r[slot_r] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r       <= in_item;
      srch_idx_r <= '0;
      cmp_v_r    <= 1'b0;
      free_r     <= 1'b0;
    end

    if (cmd.srch) begin
      cmp_idx_r <= srch_idx_r;
      cmp_v_r   <= 1'b1;
      if (srch_idx_r != SLOT_W'(SLOTS - 1)) srch_idx_r <= srch_idx_r + SLOT_W'(1);
      if (!free_r && !active_r[srch_idx_r]) begin
        free_r      <= 1'b1;
        free_slot_r <= srch_idx_r;
      end
      if (hit || srch_end) begin
        match_r <= hit;
        slot_r  <= hit ? cmp_idx_r : free_slot_r;
        rec_r   <= rec_rd;
      end
    end

    if (cmd.create) begin
      rec_r  <= rec_wr;
      vlat_r <= '0;
      vlon_r <= '0;
      nt_r   <= 1'b1;
      n_r    <= '0;
    end

    if (cmd.update) begin
      rec_r     <= rec_wr;
      vlat_r    <= upd_vlat;
      vlon_r    <= upd_vlon;
      nt_r      <= 1'b0;
      n_r       <= cnt_nxt;
      hidx_r    <= hstart[HCNT_W-1:0];
      rd_i_r    <= '0;
      acc_v_r   <= 1'b0;
      st_r      <= '0;
      stt_r     <= '0;
      sy_lat_r  <= '0;
      sy_lon_r  <= '0;
      sty_lat_r <= '0;
      sty_lon_r <= '0;
    end

    if (cmd.sums) begin
      if (rd_i_r != n_r) begin
        rd_i_r  <= rd_i_r + HCNT_W'(1);
        hidx_r  <= (hidx_r == HCNT_W'(HIST_D - 1)) ? '0 : hidx_r + HCNT_W'(1);
        acc_v_r <= 1'b1;
        acc_t_r <= rd_i_r;
      end else begin
        acc_v_r <= 1'b0;
      end
      if (acc_v_r) begin
        st_r      <= st_r + ST_W'(acc_t_r);
        stt_r     <= stt_r + STT_W'(acc_t_r) * STT_W'(acc_t_r);
        sy_lat_r  <= sy_lat_r + hla;
        sy_lon_r  <= sy_lon_r + hlo;
        sty_lat_r <= sty_lat_r + STY_W'(tla);
        sty_lon_r <= sty_lon_r + STY_W'(tlo);
      end
    end

    if (cmd.mul1) begin
      p_nsty_lat_r <= $signed({1'b0, n_r}) * sty_lat_r;
      p_nsty_lon_r <= $signed({1'b0, n_r}) * sty_lon_r;
      p_stsy_lat_r <= $signed({1'b0, st_r}) * sy_lat_r;
      p_stsy_lon_r <= $signed({1'b0, st_r}) * sy_lon_r;
      p_nstt_r     <= n_r * stt_r;
      p_stst_r     <= st_r * st_r;
    end

    if (cmd.mul2) begin
      num_lat_r <= NUM_W'(p_nsty_lat_r) - NUM_W'(p_stsy_lat_r);
      num_lon_r <= NUM_W'(p_nsty_lon_r) - NUM_W'(p_stsy_lon_r);
      d_r       <= DVS_W'(p_nstt_r - (DVS_W + 1)'(p_stst_r));
    end

    if (div_done) begin
      unique case (cmd.div_sel)
        2'd0:    a_lat_r <= div_quo[NUM_W-1:0];
        2'd1:    a_lon_r <= div_quo[NUM_W-1:0];
        2'd2:    b_lat_r <= div_quo[31:0];
        default: b_lon_r <= div_quo[31:0];
      endcase
    end

    if (cmd.bmul) begin
      am_lat_r <= a_lat_r * $signed({1'b0, st_r});
      am_lon_r <= a_lon_r * $signed({1'b0, st_r});
    end

    if (cmd.prep) begin
      k_r <= K_W'(1);
      if (n_r < HCNT_W'(2)) begin
        slope_lat_r <= vlat_r;
        slope_lon_r <= vlon_r;
        base_lat_r  <= rec_r.cur_lat;
        base_lon_r  <= rec_r.cur_lon;
        t_r         <= T_W'(stride);
      end else begin
        slope_lat_r <= a_lat_r[31:0];
        slope_lon_r <= a_lon_r[31:0];
        base_lat_r  <= b_lat_r;
        base_lon_r  <= b_lon_r;
        t_r         <= T_W'(n_r - HCNT_W'(1)) + T_W'(stride);
      end
    end

    if (cmd.emit) begin
      k_r <= k_r + K_W'(1);
      t_r <= t_r + T_W'(stride);
    end

    // result register
    out_r <= out_nxt;
  end

  always_comb begin
    stat.srch_done = hit || srch_end;
    stat.match     = match_r;
    stat.free      = free_r;
    stat.alive     = in_r.alive;
    stat.few       = cmd.create || (cnt_nxt < HCNT_W'(2));
    stat.sums_done = (rd_i_r == n_r) && !acc_v_r;
    stat.div_done  = div_done;
    stat.emit_last = (k_r == K_W'(STEPS));
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: rtl/core/track_table_ols_predictor_unit.sv
// ----------------------------------------------------------------------------
// track_table_ols_predictor_unit
// track table with least squares trajectory extrapolation
// ----------------------------------------------------------------------------
// usage
//   input: drive in_item and raise start; the item is taken at an edge where
//   start is high and busy is low. busy stays high until the last result of
//   that item has been put on the result ports.
//   results: out_valid strobes for one cycle per result item, out_item holds
//   it for that cycle only. the receiver cannot stall, so results must be
//   taken as they come. a report gives either one kind removed / ignored
//   item or fifteen predicted points on consecutive cycles, last marked.
//   sequence: the slot walk reads one slot record a cycle. removal and
//   ignored reports then pass the decide state and the remove or ignore
//   state. a new track or a track with fewer than two history points goes
//   from the create or update state straight to prediction. a fitted track
//   adds a walk over its history points, the multiply states mul1 and mul2,
//   four passes of the radix-2 divider and the prediction; the divider and
//   the single history ram read port set its length. config: apb registers
//   move_threshold (0x0) and step_stride (0x4); the user writes them only
//   while busy is low; the block does not enforce it. pready is tied high.
//   reset: rst_n low clears the slot valid bits, the sequencer and the
//   registers to 8 and 4; record and history rams need no clearing
// ----------------------------------------------------------------------------
module track_table_ols_predictor_unit import ttop_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        start,
  output logic        busy,
  input  in_t         in_item,
  // result channel
  output logic        out_valid,
  output out_t        out_item,
  // apb config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] thr_r;
  logic [3:0]  stride_r;
  cmd_t        cmd;
  stat_t       stat;
  logic        cfg_wr;

  // register file, address bit 2 picks the register
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= 16'd8;
      stride_r <= 4'd4;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_THRESHOLD: thr_r    <= pwdata[15:0];
        REG_STRIDE:    stride_r <= pwdata[3:0];
        default:       thr_r    <= thr_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = {16'd0, thr_r};
      REG_STRIDE:    prdata = {28'd0, stride_r};
      default:       prdata = '0;
    endcase
  end

  // sequencer
  ttop_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // track table, fit and point generation
  ttop_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .thr       (thr_r),
    .stride    (stride_r),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: rtl/core/ttop_chk.sv
// ----------------------------------------------------------------------------
// ttop_chk
// port level checks of the track table predictor
// ----------------------------------------------------------------------------
module ttop_chk import ttop_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_t out_item
);

  // removal and ignored items stand alone
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.kind != KIND_POINT) |-> out_item.last)
    else $error("single result item not marked last");

  // points of one report come back to back
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |=> out_valid)
    else $error("gap inside a point burst");

  // nothing follows the last item right away
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |=> !out_valid)
    else $error("result right after last item");

  // an accepted item keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

endmodule

bind track_table_ols_predictor_unit ttop_chk u_chk (.*);
